// ----- src/spp_pkg.sv -----
`default_nettype none
package spp_pkg;
    localparam int MaxJoints = 64;
    localparam int FracBits = 16;
    localparam int JointW = 6;
    localparam int StoreAw = $clog2(MaxJoints) + 4;

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        logic [JointW-1:0] joint;
        logic [JointW-1:0] parent;
        t_word [3:0] loc;
        t_word [3:0] off;
    } t_row;

    typedef struct packed {
        logic [JointW-1:0] joint;
        logic [1:0] row;
        t_word [3:0] pal;
    } t_res;

    function automatic logic signed [49:0] qmul(t_word a, t_word b);
        logic signed [63:0] p;
        p = a * b;
        return 50'(p >>> FracBits);
    endfunction

    function automatic t_word sat32(logic signed [51:0] v);
        if (v > 52'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -52'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

// ----- src/spp_front.sv -----
`default_nettype none
module spp_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    output logic              o_full,
    input  wire spp_pkg::t_row i_row,
    input  wire logic [1:0]   i_row_number,
    output logic              o_job_valid,
    input  wire logic         i_job_ready,
    output spp_pkg::t_row [3:0] o_job
);
    import spp_pkg::*;

    t_row [3:0] r_rows;
    t_row [3:0] r_job;
    logic r_valid;
    logic take;

    assign take = i_push && !o_full;
    assign o_full = r_valid && !i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job = r_job;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rows[i_row_number] <= i_row;
            if (i_row_number == 2'd3) begin
                r_job <= {i_row, r_rows[2], r_rows[1], r_rows[0]};
            end
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take && i_row_number == 2'd3) begin
            r_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ----- src/spp_back.sv -----
`default_nettype none
module spp_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_job_valid,
    output logic              o_job_ready,
    input  wire spp_pkg::t_row [3:0] i_job,
    output logic              o_res_valid,
    input  wire logic         i_res_ready,
    output spp_pkg::t_res     o_res
);
    import spp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_GLB, S_GWR, S_PAL, S_OUT} t_state;

    t_state r_state;
    t_row [3:0] r_job;
    t_word r_store [MaxJoints*16];
    t_word r_rd;
    t_word [15:0] r_par;
    t_word [15:0] r_glob;
    t_word [3:0] r_acc;
    logic [4:0] r_cnt;
    logic [1:0] r_i;
    logic [1:0] r_j;
    logic r_phase;
    logic signed [49:0] r_prod [4];
    t_res r_res;
    logic r_rvalid;

    logic [JointW-1:0] par_j;
    logic [JointW-1:0] jnt;
    logic signed [51:0] sum;
    t_word a_op [4];
    t_word b_op [4];

    assign jnt = r_job[3].joint;
    assign par_j = r_job[3].parent;
    assign o_job_ready = (r_state == S_IDLE);
    assign o_res_valid = r_rvalid;
    assign o_res = r_res;
    assign sum = 52'(r_prod[0]) + 52'(r_prod[1]) + 52'(r_prod[2]) + 52'(r_prod[3]);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_state == S_GLB) begin
                a_op[k] = r_par[{r_i, 2'(k)}];
                b_op[k] = r_job[k].loc[r_j];
            end else begin
                a_op[k] = r_glob[{r_i, 2'(k)}];
                b_op[k] = r_job[k].off[r_j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_store[{par_j, r_cnt[3:0]}];
        if (r_state == S_GWR) begin
            r_store[{jnt, r_cnt[3:0]}] <= r_glob[r_cnt[3:0]];
        end
        for (int k = 0; k < 4; k++) begin
            r_prod[k] <= qmul(a_op[k], b_op[k]);
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rvalid <= 1'b0;
        end else begin
            if (i_res_ready && r_state != S_OUT) begin
                r_rvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_cnt <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_cnt != 5'd0) begin
                        r_par[r_cnt[3:0] - 4'd1] <= r_rd;
                    end
                    if (r_cnt == 5'd16) begin
                        r_cnt <= '0;
                        {r_i, r_j} <= '0;
                        r_phase <= 1'b0;
                        if (jnt == '0) begin
                            for (int k = 0; k < 16; k++) begin
                                r_glob[k] <= r_job[k/4].loc[k%4];
                            end
                            r_state <= S_GWR;
                        end else begin
                            r_state <= S_GLB;
                        end
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_GLB: begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_glob[{r_i, r_j}] <= sat32(sum);
                        {r_i, r_j} <= {r_i, r_j} + 4'd1;
                        if ({r_i, r_j} == 4'hf) begin
                            r_state <= S_GWR;
                        end
                    end
                end
                S_GWR: begin
                    if (r_cnt[3:0] == 4'hf) begin
                        r_cnt <= '0;
                        r_phase <= 1'b0;
                        r_state <= S_PAL;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_PAL: begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_acc[r_j] <= sat32(sum);
                        r_j <= r_j + 2'd1;
                        if (r_j == 2'd3) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_rvalid || i_res_ready) begin
                        r_rvalid <= 1'b1;
                        r_res.joint <= jnt;
                        r_res.row <= r_i;
                        r_res.pal <= r_acc;
                        r_i <= r_i + 2'd1;
                        r_state <= (r_i == 2'd3) ? S_IDLE : S_PAL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rvalid && !i_res_ready |=> r_rvalid && $stable(r_res)) else $error("result lost");
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_row_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && !(r_rvalid && !i_res_ready) |=> r_rvalid) else $error("row dropped");
endmodule
`default_nettype wire

// ----- src/skeletal_pose_palette_core.sv -----
`default_nettype none
// Channel   Direction  Handshake      Payload
// joints    in         i_push/o_full  joint, parent, row number, local and offset row
// palette   out        o_empty/i_pop  joint, row, four palette elements, last flag
// A joint takes four input rows, one per cycle while o_full is low. The back end then takes
// the joint, reads the parent's global matrix from the store, forms the global matrix on the
// shared bank of four multipliers (the root copies its local matrix instead), writes it back
// and forms the palette row by row, handing each row over before starting the next.
// Reset is synchronous and clears only control state; the store holds no valid bits.
// The front takes rows while the back works and stalls only when a finished joint waits.
module skeletal_pose_palette_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [5:0]  i_joint_index,
    input  wire logic [5:0]  i_parent_joint,
    input  wire logic [1:0]  i_row_number,
    input  wire logic signed [31:0] i_local_c0,
    input  wire logic signed [31:0] i_local_c1,
    input  wire logic signed [31:0] i_local_c2,
    input  wire logic signed [31:0] i_local_c3,
    input  wire logic signed [31:0] i_offset_c0,
    input  wire logic signed [31:0] i_offset_c1,
    input  wire logic signed [31:0] i_offset_c2,
    input  wire logic signed [31:0] i_offset_c3,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [5:0]       o_out_joint,
    output logic [1:0]       o_out_row,
    output logic signed [31:0] o_pal_c0,
    output logic signed [31:0] o_pal_c1,
    output logic signed [31:0] o_pal_c2,
    output logic signed [31:0] o_pal_c3,
    output logic             o_row_last
);
    import spp_pkg::*;

    t_row in_row;
    t_row [3:0] job;
    logic job_valid;
    logic job_ready;
    logic res_valid;
    t_res res;

    assign in_row.joint = i_joint_index;
    assign in_row.parent = i_parent_joint;
    assign in_row.loc = {i_local_c3, i_local_c2, i_local_c1, i_local_c0};
    assign in_row.off = {i_offset_c3, i_offset_c2, i_offset_c1, i_offset_c0};

    spp_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_row(in_row), .i_row_number,
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    spp_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .o_job_ready(job_ready),
        .i_job(job), .o_res_valid(res_valid), .i_res_ready(i_pop), .o_res(res)
    );

    assign o_empty = !res_valid;
    assign o_out_joint = res.joint;
    assign o_out_row = res.row;
    assign o_pal_c0 = res.pal[0];
    assign o_pal_c1 = res.pal[1];
    assign o_pal_c2 = res.pal[2];
    assign o_pal_c3 = res.pal[3];
    assign o_row_last = (res.row == 2'd3);
endmodule
`default_nettype wire
